// ----- rtl/quadratic_lowest_positive_root_defines.svh -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: assertion macros
// Shared macros for the checker of the root finder.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_LOWEST_POSITIVE_ROOT_DEFINES_SVH
`define QUADRATIC_LOWEST_POSITIVE_ROOT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define QLPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qlpr implication failed");

// Condition that must never be seen outside reset.
`define QLPR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qlpr forbidden condition seen");

`endif

// ----- rtl/qlpr_pkg.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: package
// Widths, sideband types and latency shared by the root finder modules.
// ---------------------------------------------------------------------------
package qlpr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W        = 32;
  localparam int LIM_W         = 31;
  localparam int DISC_W        = 66;
  localparam int SQRT_W        = 34;
  localparam int DISC_LAT      = 3;

  typedef struct packed {
    logic              ok;
    logic              a_neg;
    logic [COEF_W-1:0] a_mag;
    logic [COEF_W-1:0] b;
    logic [LIM_W-1:0]  lim;
  } side_t;

  typedef struct packed {
    logic             ok;
    logic [LIM_W-1:0] lim;
  } tail_t;

  function automatic int latency(int frac);
    return DISC_LAT + SQRT_W + 1 + (SQRT_W + 1 + frac) + 1;
  endfunction

endpackage

// ----- rtl/qlpr_disc.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: discriminant
// Three stages: magnitudes, the two products, then b*b - 4ac at full width.
// ---------------------------------------------------------------------------
module qlpr_disc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [qlpr_pkg::COEF_W-1:0]  coef_a_i,
  input  logic signed [qlpr_pkg::COEF_W-1:0]  coef_b_i,
  input  logic signed [qlpr_pkg::COEF_W-1:0]  coef_c_i,
  input  logic        [qlpr_pkg::LIM_W-1:0]   limit_i,
  output logic                                valid_o,
  output logic        [qlpr_pkg::DISC_W-1:0]  rad_o,
  output qlpr_pkg::side_t                     side_o
);

  localparam int CW = qlpr_pkg::COEF_W;
  localparam int DW = qlpr_pkg::DISC_W;

  logic            v1_q, v2_q, v3_q;
  qlpr_pkg::side_t s1_d, s1_q, s2_q, s3_d, s3_q;
  logic [CW-1:0]   bmag1_d, bmag1_q, cmag1_d, cmag1_q;
  logic            cneg1_q;
  logic [2*CW-1:0] b2_d, b2_q, p_d, p_q;
  logic            pos4_d, pos4_q;
  logic [DW-1:0]   p4, b2e, rad_d, rad_q;
  logic            neg;

  always_comb begin
    s1_d       = '0;
    s1_d.ok    = (coef_a_i != '0);
    s1_d.a_neg = coef_a_i[CW-1];
    s1_d.a_mag = coef_a_i[CW-1] ? CW'(-coef_a_i) : CW'(coef_a_i);
    s1_d.b     = coef_b_i;
    s1_d.lim   = limit_i;
    bmag1_d    = coef_b_i[CW-1] ? CW'(-coef_b_i) : CW'(coef_b_i);
    cmag1_d    = coef_c_i[CW-1] ? CW'(-coef_c_i) : CW'(coef_c_i);
  end

  assign b2_d   = bmag1_q * bmag1_q;
  assign p_d    = s1_q.a_mag * cmag1_q;
  assign pos4_d = (s1_q.a_neg == cneg1_q) && (cmag1_q != '0);

  always_comb begin
    p4    = {p_q, 2'b00};
    b2e   = {2'b00, b2_q};
    neg   = pos4_q && (p4 > b2e);
    rad_d = pos4_q ? (b2e - p4) : (b2e + p4);
    s3_d  = s2_q;
    s3_d.ok = s2_q.ok && !neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    bmag1_q <= bmag1_d;
    cmag1_q <= cmag1_d;
    cneg1_q <= coef_c_i[CW-1];
    s2_q    <= s1_q;
    b2_q    <= b2_d;
    p_q     <= p_d;
    pos4_q  <= pos4_d;
    s3_q    <= s3_d;
    rad_q   <= rad_d;
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;
  assign side_o  = s3_q;

endmodule

// ----- rtl/qlpr_sqrt.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: square root
// Pipelined floor square root, one result bit per stage.
// ---------------------------------------------------------------------------
module qlpr_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [qlpr_pkg::DISC_W-1:0]        rad_i,
  input  qlpr_pkg::side_t                    side_i,
  output logic                               valid_o,
  output logic [qlpr_pkg::SQRT_W-1:0]        root_o,
  output qlpr_pkg::side_t                    side_o
);

  localparam int N  = qlpr_pkg::SQRT_W;
  localparam int DW = qlpr_pkg::DISC_W;
  localparam int TW = DW + 2;

  logic [DW-1:0]   rem_q  [N];
  logic [N-1:0]    r_q    [N];
  logic            v_q    [N];
  qlpr_pkg::side_t side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int K = N - 1 - i;
    logic [DW-1:0]   rem_in, rem_d;
    logic [N-1:0]    r_in, r_d;
    logic            v_in;
    qlpr_pkg::side_t side_in;
    logic [TW-1:0]   trial;
    logic            fits;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign r_in    = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign r_in    = r_q[i-1];
      assign v_in    = v_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      trial = (TW'(r_in) << (K + 1)) | (TW'(1) << (2 * K));
      fits  = ({2'b00, rem_in} >= trial);
      rem_d = fits ? (rem_in - trial[DW-1:0]) : rem_in;
      r_d   = fits ? (r_in | (N'(1) << K)) : r_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      r_q[i]    <= r_d;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ----- rtl/qlpr_div.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: divider
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// ---------------------------------------------------------------------------
module qlpr_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 33
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             neg_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             neg_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] q_q   [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic             neg_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in, rem_d;
    logic [NUM_W-1:0] num_in, q_in;
    logic             neg_in, ge;
    logic [DEN_W:0]   sh, diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign q_in   = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign num_in = num_q[i-1];
      assign q_in   = q_q[i-1];
      assign den_in = den_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    always_comb begin
      sh    = {rem_in, num_in[NUM_W-1]};
      diff  = sh - {1'b0, den_in};
      ge    = (sh >= {1'b0, den_in});
      rem_d = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      num_q[i] <= num_in << 1;
      q_q[i]   <= {q_in[NUM_W-2:0], ge};
      den_q[i] <= den_in;
      neg_q[i] <= neg_in;
    end
  end

  assign quot_o = q_q[NUM_W-1];
  assign neg_o  = neg_q[NUM_W-1];

endmodule

// ----- rtl/quadratic_lowest_positive_root.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root
// Smallest root of a*x*x + b*x + c strictly between zero and a limit.
// ---------------------------------------------------------------------------
// Usage: drive coef_a_i, coef_b_i, coef_c_i (signed Q16.16) and limit_i with
// start_i high for one cycle per item. An item is taken when start_i is high
// and busy_o is low; busy_o stays low, so a new item may enter every cycle.
// Each item returns one result beat: done_o is high for exactly one cycle with
// found_o and root_value_o; root_value_o is zero when found_o is low.
// Throughput is one item per cycle. The square root resolves one result bit
// per stage over 34 stages, and the two dividers one quotient bit per stage.
// Reset clears all valid bits, so no beat is in flight after reset.
// The receiver cannot stall; a result appears once and is not held.
// ---------------------------------------------------------------------------
module quadratic_lowest_positive_root #(
  parameter int FRAC_BITS = qlpr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [qlpr_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [qlpr_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [qlpr_pkg::COEF_W-1:0] coef_c_i,
  input  logic        [qlpr_pkg::LIM_W-1:0]  limit_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic        [qlpr_pkg::LIM_W-1:0]  root_value_o
);

  localparam int SW    = qlpr_pkg::SQRT_W;
  localparam int CW    = qlpr_pkg::COEF_W;
  localparam int LW    = qlpr_pkg::LIM_W;
  localparam int MW    = SW + 1;
  localparam int NW    = MW + 1;
  localparam int NUM_W = MW + FRAC_BITS;
  localparam int DEN_W = CW + 1;

  logic                  dv, sv;
  logic [qlpr_pkg::DISC_W-1:0] rad;
  qlpr_pkg::side_t       dside, sside;
  logic [SW-1:0]         sroot;

  qlpr_disc u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .limit_i  (limit_i),
    .valid_o  (dv),
    .rad_o    (rad),
    .side_o   (dside)
  );

  qlpr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv),
    .rad_i   (rad),
    .side_i  (dside),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside)
  );

  logic signed [NW-1:0] bx, sx, n1, n2;
  logic [MW-1:0]        mag1, mag2;
  logic [NUM_W-1:0]     num1_q, num2_q;
  logic [DEN_W-1:0]     den_q;
  logic                 neg1_q, neg2_q, rv_q;
  qlpr_pkg::tail_t      rt_d, rt_q;

  always_comb begin
    bx      = {{(NW-CW){sside.b[CW-1]}}, sside.b};
    sx      = {{(NW-SW){1'b0}}, sroot};
    n1      = -bx - sx;
    n2      = -bx + sx;
    mag1    = n1[NW-1] ? MW'(-n1) : MW'(n1);
    mag2    = n2[NW-1] ? MW'(-n2) : MW'(n2);
    rt_d.ok = sside.ok;
    rt_d.lim = sside.lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q <= {mag1, {FRAC_BITS{1'b0}}};
    num2_q <= {mag2, {FRAC_BITS{1'b0}}};
    den_q  <= {sside.a_mag, 1'b0};
    neg1_q <= n1[NW-1] ^ sside.a_neg;
    neg2_q <= n2[NW-1] ^ sside.a_neg;
    rt_q   <= rt_d;
  end

  logic [NUM_W-1:0] q1, q2;
  logic             qn1, qn2;

  qlpr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_lo (
    .clk_i  (clk_i),
    .num_i  (num1_q),
    .den_i  (den_q),
    .neg_i  (neg1_q),
    .quot_o (q1),
    .neg_o  (qn1)
  );

  qlpr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_hi (
    .clk_i  (clk_i),
    .num_i  (num2_q),
    .den_i  (den_q),
    .neg_i  (neg2_q),
    .quot_o (q2),
    .neg_o  (qn2)
  );

  qlpr_pkg::tail_t tl_q [NUM_W];
  logic            vl_q [NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_W; i++) begin
        vl_q[i] <= 1'b0;
      end
    end else begin
      vl_q[0] <= rv_q;
      for (int i = 1; i < NUM_W; i++) begin
        vl_q[i] <= vl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tl_q[0] <= rt_q;
    for (int i = 1; i < NUM_W; i++) begin
      tl_q[i] <= tl_q[i-1];
    end
  end

  logic signed [NUM_W:0] x1, x2, xl, xh, lim_x;
  logic                  okl, okh, found_d;
  logic [LW-1:0]         root_d;
  qlpr_pkg::tail_t       tf;

  always_comb begin
    tf     = tl_q[NUM_W-1];
    x1     = qn1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    x2     = qn2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    xl     = (x1 > x2) ? x2 : x1;
    xh     = (x1 > x2) ? x1 : x2;
    lim_x  = $signed({{(NUM_W+1-LW){1'b0}}, tf.lim});
    okl    = (xl > 0) && (xl < lim_x);
    okh    = (xh > 0) && (xh < lim_x);
    found_d = tf.ok && (okl || okh);
    if (!found_d) begin
      root_d = '0;
    end else if (okl) begin
      root_d = xl[LW-1:0];
    end else begin
      root_d = xh[LW-1:0];
    end
  end

  logic          done_q, found_q;
  logic [LW-1:0] root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      found_q <= 1'b0;
      root_q  <= '0;
    end else begin
      done_q  <= vl_q[NUM_W-1];
      found_q <= found_d;
      root_q  <= root_d;
    end
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign root_value_o = root_q;

endmodule

// ----- rtl/qlpr_check.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: port checker
// Timing and result checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "quadratic_lowest_positive_root_defines.svh"

module qlpr_check #(
  parameter int FRAC_BITS = qlpr_pkg::FRAC_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic signed [qlpr_pkg::COEF_W-1:0] coef_a_i,
  input logic signed [qlpr_pkg::COEF_W-1:0] coef_b_i,
  input logic signed [qlpr_pkg::COEF_W-1:0] coef_c_i,
  input logic        [qlpr_pkg::LIM_W-1:0]  limit_i,
  input logic                               done_o,
  input logic                               found_o,
  input logic        [qlpr_pkg::LIM_W-1:0]  root_value_o
);

  localparam int LAT = qlpr_pkg::latency(FRAC_BITS);

  `QLPR_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)
  `QLPR_ASSERT_IMP(a_beat_returns, clk_i, rst_ni, start_i && !busy_o, ##LAT done_o)
  `QLPR_ASSERT_IMP(a_no_stray_beat, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT))
  `QLPR_ASSERT_IMP(a_root_in_range, clk_i, rst_ni, done_o && found_o, (root_value_o != '0) && (root_value_o < $past(limit_i, LAT)))
  `QLPR_ASSERT_IMP(a_zero_if_none, clk_i, rst_ni, done_o && !found_o, root_value_o == '0)

endmodule

bind quadratic_lowest_positive_root qlpr_check #(.FRAC_BITS(FRAC_BITS)) u_qlpr_check (.*);

// ----- sim/quadratic_lowest_positive_root_test.sv -----
// ---------------------------------------------------------------------------
// Quadratic lowest positive root: testbench
// Feeds directed and random quadratics and checks each result beat against a
// predictor that solves the same fixed-point problem.
// ---------------------------------------------------------------------------
module quadratic_lowest_positive_root_test;

  localparam int FRAC = qlpr_pkg::FRAC_BITS_DEF;
  localparam int CW   = qlpr_pkg::COEF_W;
  localparam int LW   = qlpr_pkg::LIM_W;
  localparam int DW   = qlpr_pkg::DISC_W;
  localparam int LAT  = 3 + qlpr_pkg::SQRT_W + 1 + (qlpr_pkg::SQRT_W + 1 + FRAC) + 1;
  localparam int WATCHDOG_LIMIT = 20 * LAT + 2000;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic [LW-1:0]        lim;
  } quad_t;

  typedef struct packed {
    logic          found;
    logic [LW-1:0] root;
  } root_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic [LW-1:0] limit_i = '0;
  logic done_o, found_o;
  logic [LW-1:0] root_value_o;

  quad_t quad_q[$];
  root_t root_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_drain = 0;
  bit calm = 0;

  quadratic_lowest_positive_root dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic void add_quad(quad_t x);
    quad_q = {quad_q, x};
  endfunction

  function automatic void add_root(root_t r);
    root_q = {root_q, r};
  endfunction

  function automatic logic [33:0] floor_sqrt(logic [DW-1:0] d);
    logic [33:0] r, t;
    r = '0;
    for (int k = 33; k >= 0; k--) begin
      t = r | (34'd1 << k);
      if ({34'd0, t} * {34'd0, t} <= {2'b0, d}) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [67:0] div_root(logic signed [67:0] n,
                                                  logic signed [67:0] a);
    logic [67:0] num, den, q;
    num = (n < 0 ? -n : n) << FRAC;
    den = 2 * (a < 0 ? -a : a);
    q = num / den;
    return ((n < 0) != (a < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic root_t lowest_root(quad_t x);
    logic signed [67:0] a, b, c, disc, s, r1, r2, t, lim;
    root_t res;
    res = '0;
    a = x.a; b = x.b; c = x.c; lim = {37'd0, x.lim};
    if (a == 0) return res;
    disc = b * b - 4 * a * c;
    if (disc < 0) return res;
    s = $signed({34'd0, floor_sqrt(disc[DW-1:0])});
    r1 = div_root(-b - s, a);
    r2 = div_root(-b + s, a);
    if (r1 > r2) begin
      t = r1; r1 = r2; r2 = t;
    end
    if (r1 > 0 && r1 < lim) res = '{1'b1, r1[LW-1:0]};
    else if (r2 > 0 && r2 < lim) res = '{1'b1, r2[LW-1:0]};
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff;
      2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
      3: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff;
      4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $signed($urandom_range(0, 32'hfffff)) - 32'sh7ffff;
    endcase
  endfunction

  function automatic quad_t well_formed();
    quad_t x;
    logic signed [31:0] r1, r2, k;
    r1 = $signed($urandom_range(0, 32'h7ffff)) - 32'sh1ffff;
    r2 = $signed($urandom_range(0, 32'h7ffff)) - 32'sh1ffff;
    k = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
    x.a = k <<< 16;
    x.b = -k * (r1 + r2);
    x.c = 32'((64'(k) * 64'(r1) * 64'(r2)) >>> 16);
    x.lim = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h60000));
    return x;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        add_root(lowest_root('{coef_a_i, coef_b_i, coef_c_i, limit_i}));
        void'(quad_q.pop_front());
      end
      if (quad_q.size() != 0 && !(hold_drain && root_q.size() != 0) &&
          (calm || $urandom_range(0, 99) >= 19)) begin
        start_i <= 1'b1;
        {coef_a_i, coef_b_i, coef_c_i, limit_i} <= quad_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni) begin
      idle_cycles <= (done_o || (start_i && !busy_o)) ? 0 : idle_cycles + 1;
      if (done_o) begin
        if (root_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: found %0b root %h", found_o,
                                         root_value_o);
        end else begin
          want = root_q.pop_front();
          if (want.found !== found_o || want.root !== root_value_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found %0b root %h, got found %0b root %h",
                       want.found, want.root, found_o, root_value_o);
          end
        end
      end
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    quad_t x;
    add_quad('{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 31'h0010_0000});
    add_quad('{32'h0, 32'h0001_0000, 32'h0001_0000, 31'h7fff_ffff});
    add_quad('{32'h0001_0000, 32'h0, 32'h0001_0000, 31'h7fff_ffff});
    add_quad('{32'h0001_0000, 32'h0, 32'h0, 31'h7fff_ffff});
    add_quad('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff});
    add_quad('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff});
    add_quad('{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff});
    add_quad('{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0});
    add_quad('{32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 31'h7fff_ffff});
    add_quad('{32'h0000_0001, 32'h0, 32'hffff_ffff, 31'h7fff_ffff});
    add_quad('{32'h7fff_ffff, 32'h0, 32'hffff_ffff, 31'h7fff_ffff});
    add_quad('{32'hffff_0000, 32'h0003_0000, 32'hfffe_0000, 31'h0001_8000});
    add_quad('{32'hffff_0000, 32'h0003_0000, 32'hfffe_0000, 31'h0001_0000});
    add_quad('{32'h0001_0000, 32'h0001_0000, 32'hfffe_0000, 31'h0002_0000});
    add_quad('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 31'h7fff_ffff});
    add_quad('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h5555_5555});
    add_quad('{32'h0002_0000, 32'hffff_ffff, 32'h0, 31'h2aaa_aaaa});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (quad_q.size() != 0) @(posedge clk_i);
    hold_drain <= 1'b1;
    for (int i = 0; i < 1350; i++) begin
      if (i == 100) hold_drain <= 1'b0;
      calm <= (i >= 600 && i < 800);
      if ($urandom_range(0, 9) < 7) x = well_formed();
      else x = '{rand_coef(), rand_coef(), rand_coef(), 31'($urandom())};
      add_quad(x);
      while (quad_q.size() > 4) @(posedge clk_i);
      if (i == 50) hold_drain <= 1'b1;
    end
    while (quad_q.size() != 0) @(posedge clk_i);
    while (root_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (mismatches == 0 && root_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
